/* design/cstk_pkg.sv */
// Shared types and constants for the causal top-k selection mask.
`timescale 1ns / 1ps
`default_nettype none

package cstk_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int SCORE_W        = 32;
    localparam int QPOS_W         = 16;
    localparam int TOPK_W         = 7;
    localparam int RATE_W         = 16;
    localparam int IDX_W          = 6;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 16;
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 8;

    localparam logic [TOPK_W-1:0]        TOP_K_RST  = 7'd16;
    localparam logic [RATE_W-1:0]        RATE_RST   = 16'd4;
    localparam logic signed [SCORE_W-1:0] MASK_VALUE = 32'sh8000_0000;
    localparam logic signed [SCORE_W-1:0] SCORE_SAT  = 32'sh8000_0001;

    localparam logic [CFG_ADDR_W-1:0] REG_TOP_K = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE  = 1'b1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_DIV,
        S_SEARCH,
        S_PASS_END,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

endpackage

`default_nettype wire

/* design/causal_topk_selection_mask.sv */
// Top level of the causal top-k block selection mask.
`timescale 1ns / 1ps
`default_nettype none

// A row of scores is taken one transaction per cycle into a score memory until the
// transaction with tlast closes it. A serial divider then forms the causal limit, and
// the threshold search walks the stored row once per distinct score value from the
// top until the top-k count is reached (at most k passes). The keep bits then leave
// one per transaction, read back through the single memory read port; no input is
// taken while a row is being searched or emitted.
module causal_topk_selection_mask import cstk_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,   // score[31:0], query_pos[47:32]
    input  wire logic                  s_axis_tlast,   // row_last
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata,   // keep[0], block_index[6:1], zero[7]
    output logic                       m_axis_tlast,   // mask_last
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);

    t_state r_state;
    t_state n_state;

    logic [TOPK_W-1:0]         r_top_k;
    logic [RATE_W-1:0]         r_rate;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_n;
    logic [QPOS_W-1:0]         r_allowed;
    logic [CW-1:0]             r_k;
    logic [CW-1:0]             r_idx;
    logic                      r_pv;
    logic [CW-1:0]             r_pidx;
    logic                      r_have_max;
    logic signed [SCORE_W-1:0] r_cur_max;
    logic [CW-1:0]             r_cnt;
    logic                      r_has_bound;
    logic signed [SCORE_W-1:0] r_bound;
    logic [CW-1:0]             r_cum;
    logic signed [SCORE_W-1:0] r_thr;
    logic signed [SCORE_W-1:0] r_mem [MAX_BLOCKS];
    logic signed [SCORE_W-1:0] r_rd_data;
    logic                      r_out_valid;
    logic                      r_out_keep;
    logic [IDX_W-1:0]          r_out_index;
    logic                      r_out_last;

    logic                      s_acc;
    logic                      row_end;
    logic                      wr_en;
    logic [AW-1:0]             rd_addr;
    logic signed [SCORE_W-1:0] in_score;
    logic signed [SCORE_W-1:0] sat_score;
    logic [QPOS_W-1:0]         in_qpos;
    logic                      issue;
    logic                      last_proc;
    logic                      out_free;
    logic                      emit_load;
    logic                      emit_last;
    logic                      div_done;
    logic [QPOS_W-1:0]         div_quo;
    logic                      causal_p;
    logic                      causal_e;
    logic signed [SCORE_W-1:0] m_val;
    logic                      consider;
    logic [CW:0]               cum_sum;
    logic                      pass_hit;
    logic [TOPK_W-1:0]         n_ext;
    logic [TOPK_W-1:0]         k_sel;

    assign in_score  = s_axis_tdata[SCORE_W-1:0];
    assign in_qpos   = s_axis_tdata[SCORE_W +: QPOS_W];
    assign sat_score = (in_score == MASK_VALUE) ? SCORE_SAT : in_score;

    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign row_end = s_acc && s_axis_tlast;

    assign last_proc = r_pv && (r_pidx == (r_n - CW'(1)));
    assign out_free  = !r_out_valid || m_axis_tready;
    assign emit_last = (r_idx == (r_n - CW'(1)));
    assign causal_p  = QPOS_W'(r_pidx) < r_allowed;
    assign causal_e  = QPOS_W'(r_idx) < r_allowed;
    assign m_val     = causal_p ? r_rd_data : MASK_VALUE;
    assign consider  = !r_has_bound || (m_val < r_bound);
    assign cum_sum   = {1'b0, r_cum} + {1'b0, r_cnt};
    assign pass_hit  = cum_sum >= {1'b0, r_k};

    assign n_ext = TOPK_W'(r_n);
    always_comb begin
        k_sel = (r_top_k < n_ext) ? r_top_k : n_ext;
        if (k_sel == '0) begin
            k_sel = TOPK_W'(1);
        end
    end

    cstk_div #(
        .W (QPOS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (row_end),
        .i_dividend (in_qpos),
        .i_divisor  (r_rate),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (row_end) n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (last_proc) n_state = S_PASS_END;
            end
            S_PASS_END: begin
                n_state = pass_hit ? S_EMIT_RD : S_SEARCH;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) n_state = emit_last ? S_LOAD : S_EMIT_RD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_LOAD);
        issue         = (r_state == S_SEARCH) && (r_idx < r_n);
        emit_load     = (r_state == S_EMIT_LD) && out_free;
        wr_en         = s_acc && (r_count < MAX_CNT);
        rd_addr       = r_idx[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= sat_score;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_top_k     <= TOP_K_RST;
            r_rate      <= RATE_RST;
            r_count     <= '0;
            r_pv        <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_TOP_K: r_top_k <= i_cfg_wdata[TOPK_W-1:0];
                    REG_RATE:  r_rate  <= i_cfg_wdata[RATE_W-1:0];
                    default:   r_rate  <= r_rate;
                endcase
            end

            if (s_acc) begin
                if (s_axis_tlast) begin
                    r_count <= '0;
                    r_n     <= (r_count < MAX_CNT) ? (r_count + CW'(1)) : r_count;
                end else if (r_count < MAX_CNT) begin
                    r_count <= r_count + CW'(1);
                end
            end

            if (div_done) begin
                r_allowed   <= div_quo;
                r_k         <= CW'(k_sel);
                r_idx       <= '0;
                r_have_max  <= 1'b0;
                r_has_bound <= 1'b0;
                r_cum       <= '0;
            end

            r_pv   <= issue;
            r_pidx <= r_idx;
            if (issue) begin
                r_idx <= r_idx + CW'(1);
            end

            if (r_pv && consider) begin
                if (!r_have_max || (m_val > r_cur_max)) begin
                    r_cur_max  <= m_val;
                    r_cnt      <= CW'(1);
                    r_have_max <= 1'b1;
                end else if (m_val == r_cur_max) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end

            if (r_state == S_PASS_END) begin
                r_idx <= '0;
                if (pass_hit) begin
                    r_thr <= r_cur_max;
                end else begin
                    r_bound     <= r_cur_max;
                    r_has_bound <= 1'b1;
                    r_have_max  <= 1'b0;
                    r_cum       <= cum_sum[CW-1:0];
                end
            end

            if (emit_load) begin
                r_out_valid <= 1'b1;
                r_out_keep  <= causal_e && (r_rd_data >= r_thr);
                r_out_index <= IDX_W'(r_idx);
                r_out_last  <= emit_last;
                r_idx       <= r_idx + CW'(1);
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_index, r_out_keep};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

/* design/cstk_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module cstk_div import cstk_pkg::*; #(
    parameter int W = RATE_W
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [W-1:0] i_divisor,
    output logic              o_done,
    output logic [W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dvs;
    logic [W:0]       rem_sh;
    logic [W:0]       diff;

    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= (i_divisor == '0) ? W'(1) : i_divisor;
            end else if (r_busy) begin
                if (!diff[W]) begin
                    r_rem <= diff[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* design/cstk_chk.sv */
// Port-level assertions for the causal top-k selection mask, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cstk_chk import cstk_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  s_axis_tlast,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [M_TDATA_W-1:0]  m_axis_tdata,
    input wire logic                  m_axis_tlast,
    input wire logic                  i_cfg_we
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("Stalled output transaction changed.");

    a_row_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("Input accepted straight after the end of a row.");

    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("Input open while a row is still being emitted.");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> (s_axis_tready && !m_axis_tvalid))
        else $error("Configuration written while a row was in flight.");

endmodule

bind causal_topk_selection_mask cstk_chk u_cstk_chk (.*);

`default_nettype wire

/* test/tb_causal_topk_selection_mask.sv */
// Self-checking testbench for the causal top-k block selection mask.
`timescale 1ns / 1ps

module tb_causal_topk_selection_mask;
    import cstk_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned PHASE_ITEMS   = 60;

    typedef struct packed {
        logic             keep;
        logic [IDX_W-1:0] block_index;
        logic             mask_last;
    } t_keep_bit;

    class mask_scoreboard;
        logic signed [SCORE_W-1:0] row_scores [MAX_BLOCKS_DEF];
        int unsigned               row_len;
        logic [QPOS_W-1:0]         row_qpos;
        logic [TOPK_W-1:0]         top_k;
        logic [RATE_W-1:0]         rate;
        t_keep_bit                 expected_bits [$];
        int unsigned               errors;

        function new();
            row_len  = 0;
            row_qpos = '0;
            top_k    = TOP_K_RST;
            rate     = RATE_RST;
            errors   = 0;
        endfunction

        function void load_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_TOP_K: top_k = data[TOPK_W-1:0];
                REG_RATE:  rate  = data[RATE_W-1:0];
                default: ;
            endcase
        endfunction

        // Stores one score; a closing transaction yields the keep bits of the whole row.
        function void note_score(logic signed [SCORE_W-1:0] score, logic [QPOS_W-1:0] qpos,
                                 logic last);
            logic signed [SCORE_W-1:0] masked [MAX_BLOCKS_DEF];
            logic signed [SCORE_W-1:0] ranked [MAX_BLOCKS_DEF];
            logic signed [SCORE_W-1:0] swap_val;
            logic signed [SCORE_W-1:0] thr;
            int unsigned               n, k, rate_eff, allowed, i, j, best;
            t_keep_bit                 kb;
            if (score == MASK_VALUE) score = SCORE_SAT;
            row_qpos = qpos;
            if (row_len < MAX_BLOCKS_DEF) begin
                row_scores[row_len] = score;
                row_len++;
            end
            if (!last) return;
            n       = row_len;
            row_len = 0;
            if (n == 0) return;
            rate_eff = (rate == 0) ? 1 : 32'(rate);
            allowed  = 32'(row_qpos) / rate_eff;
            k = (32'(top_k) < n) ? 32'(top_k) : n;
            if (k == 0) k = 1;
            for (i = 0; i < n; i++) begin
                masked[i] = (i < allowed) ? row_scores[i] : MASK_VALUE;
                ranked[i] = masked[i];
            end
            for (i = 0; i < k; i++) begin
                best = i;
                for (j = i + 1; j < n; j++) begin
                    if (ranked[j] > ranked[best]) best = j;
                end
                swap_val     = ranked[i];
                ranked[i]    = ranked[best];
                ranked[best] = swap_val;
            end
            thr = ranked[k-1];
            for (i = 0; i < n; i++) begin
                kb.keep        = (i < allowed) && (masked[i] >= thr);
                kb.block_index = i[IDX_W-1:0];
                kb.mask_last   = (i == n - 1);
                expected_bits.push_back(kb);
            end
        endfunction

        function void check_bit(logic [M_TDATA_W-1:0] tdata, logic tlast);
            t_keep_bit exp_bit;
            if (expected_bits.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, actual keep %0b index %0d last %0b",
                         $time, tdata[0], tdata[IDX_W:1], tlast);
                return;
            end
            exp_bit = expected_bits.pop_front();
            if (tdata[0] !== exp_bit.keep) begin
                errors++;
                $display("%0t: keep mismatch, expected %0b, actual %0b",
                         $time, exp_bit.keep, tdata[0]);
            end
            if (tdata[IDX_W:1] !== exp_bit.block_index) begin
                errors++;
                $display("%0t: block_index mismatch, expected %0d, actual %0d",
                         $time, exp_bit.block_index, tdata[IDX_W:1]);
            end
            if (tlast !== exp_bit.mask_last) begin
                errors++;
                $display("%0t: mask_last mismatch, expected %0b, actual %0b",
                         $time, exp_bit.mask_last, tlast);
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    logic           tx_idle_on = 1'b0;
    logic           rx_idle_on = 1'b0;
    mask_scoreboard sb;

    causal_topk_selection_mask DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SCORE_W-1:0] pick_score();
        int unsigned r;
        int          v;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            v = int'($urandom_range(0, 6)) - 3;
            return SCORE_W'(v) << 16;
        end
        if (r < 50) begin
            case ($urandom_range(0, 4))
                0:       return 32'h7FFF_FFFF;
                1:       return MASK_VALUE;
                2:       return SCORE_SAT;
                3:       return 32'hFFFF_FFFF;
                default: return '0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic int unsigned pick_row_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 12);
        if (r < 92) return $urandom_range(13, 40);
        return $urandom_range(41, 70);
    endfunction

    // Results are taken here; the ready line stalls in random stretches when rx_idle_on is set.
    initial begin
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_bit(m_axis_tdata, m_axis_tlast);
            if (stall != 0) begin
                stall--;
            end else if (rx_idle_on) begin
                stall = idle_len();
            end
            m_axis_tready <= (stall == 0);
        end
    end

    task automatic send_score(input logic [SCORE_W-1:0] score, input logic [QPOS_W-1:0] qpos,
                              input logic last);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {qpos, score};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_score(score, qpos, last);
        gap = tx_idle_on ? idle_len() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // The query position of the closing transaction is mostly chosen so that the
    // causal limit falls within or just past the row.
    task automatic send_row(input int unsigned len);
        int unsigned       i, rate_eff, lim;
        logic [QPOS_W-1:0] qpos;
        rate_eff = (sb.rate == 0) ? 1 : 32'(sb.rate);
        for (i = 0; i + 1 < len; i++)
            send_score(pick_score(), QPOS_W'($urandom), 1'b0);
        if ($urandom_range(0, 9) < 7) begin
            lim  = rate_eff * $urandom_range(0, len + 2) + $urandom_range(0, rate_eff - 1);
            qpos = (lim > 32'hFFFF) ? 16'hFFFF : lim[QPOS_W-1:0];
        end else begin
            qpos = QPOS_W'($urandom);
        end
        send_score(pick_score(), qpos, 1'b1);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_bits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= CFG_DATA_W'(value);
        @(posedge i_clk);
        sb.load_reg(addr, CFG_DATA_W'(value));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned phase, sent, len, kval, rval;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: extreme scores with the most negative one saturated.
        send_score(32'h7FFF_FFFF, 16'd0,    1'b0);
        send_score(MASK_VALUE,    16'd1234, 1'b0);
        send_score(SCORE_SAT,     16'd0,    1'b0);
        send_score(32'h0000_0000, 16'd0,    1'b0);
        send_score(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        // Single block with nothing causal.
        send_score(32'h1234_5678, 16'd3,    1'b1);
        // The position on the closing transaction decides the causal limit.
        send_score(32'd100,       16'hFFFF, 1'b0);
        send_score(32'd200,       16'hFFFF, 1'b0);
        send_score(32'd300,       16'd8,    1'b1);

        settle();
        write_reg(REG_TOP_K, 0);
        write_reg(REG_RATE, 0);
        // Ties at the threshold keep more than k blocks.
        send_score(32'h0007_0000, 16'd100, 1'b0);
        send_score(32'h0007_0000, 16'd100, 1'b0);
        send_score(32'hFFFD_0000, 16'd100, 1'b0);
        send_score(32'h0007_0000, 16'd100, 1'b1);
        send_score(MASK_VALUE,    16'd2,   1'b0);
        send_score(SCORE_SAT,     16'd2,   1'b0);
        send_score(32'd5,         16'd2,   1'b1);

        settle();
        write_reg(REG_TOP_K, 127);
        write_reg(REG_RATE, 65535);
        send_score(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_score(32'h7FFF_FFFF, 16'hFFFF, 1'b1);

        for (phase = 0; phase < 6; phase++) begin
            settle();
            case (phase)
                0: begin kval = 64;  rval = 1;     end
                1: begin kval = 0;   rval = 0;     end
                2: begin kval = 127; rval = 65535; end
                3: begin kval = 1;   rval = 2;     end
                4: begin
                    kval = $urandom_range(0, 127);
                    rval = $urandom_range(1, 16);
                end
                default: begin
                    kval = $urandom_range(2, 20);
                    rval = $urandom_range(1, 65535);
                end
            endcase
            write_reg(REG_TOP_K, kval);
            write_reg(REG_RATE, rval);
            tx_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            sent = 0;
            if (phase == 0) begin
                // More scores than the row store holds.
                send_row(66);
                sent = 66;
            end
            while (sent < PHASE_ITEMS) begin
                len = pick_row_len();
                send_row(len);
                sent += len;
                if ($urandom_range(0, 9) == 0) settle();
            end
        end

        settle();
        if (sb.errors == 0 && sb.expected_bits.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
